### src/rrs_pkg.sv
`timescale 1ns / 1ps
// rrs_pkg: shared types and constants for the round-robin scheduler
// no dependencies; imported by rrs_alu and round_robin_scheduler_with_sleep
package rrs_pkg;

    localparam int DEF_MAX_THREADS = 16;
    localparam int DEF_TICK_BITS   = 32;

    localparam int ID_W     = 4;
    localparam int CMD_W    = 2;
    localparam int DELAY_W  = 16;
    localparam int WOKEN_W  = 5;
    localparam int STATUS_W = 2;
    localparam int QUANT_W  = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [QUANT_W-1:0] QUANT_RESET = 8'd10;

    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SLEEP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EXIT  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_ADMIT = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_RUN_ENABLE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_TICKS = 1'd1;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_GT  = 1'b1
    } alu_op_t;

endpackage

### src/rrs_alu.sv
`timescale 1ns / 1ps
// rrs_alu: shared adder used for tick increment, wake time sum and wake compare
// depends on rrs_pkg
module rrs_alu #(
    parameter int TICK_BITS = rrs_pkg::DEF_TICK_BITS
) (
    input  rrs_pkg::alu_op_t       op,
    input  logic [TICK_BITS-1:0]   a,
    input  logic [TICK_BITS-1:0]   b,
    output logic [TICK_BITS-1:0]   sum,
    output logic                   a_gt_b
);
    import rrs_pkg::*;

    logic [TICK_BITS-1:0] x;
    logic [TICK_BITS-1:0] y;
    logic                 cin;
    logic [TICK_BITS:0]   total;

    // compare: b - a borrows exactly when a > b
    always_comb
    begin
        if (op == ALU_GT)
        begin
            x   = b;
            y   = ~a;
            cin = 1'b1;
        end
        else
        begin
            x   = a;
            y   = b;
            cin = 1'b0;
        end
        total  = {1'b0, x} + {1'b0, y} + {{TICK_BITS{1'b0}}, cin};
        sum    = total[TICK_BITS-1:0];
        a_gt_b = ~total[TICK_BITS];
    end

endmodule

### src/round_robin_scheduler_with_sleep.sv
`timescale 1ns / 1ps
// sequence: admit or disabled tick runs S_PREV then S_FIN; other items may also run
// the wake scan and ring/sleep-list compaction, which move one entry per cycle;
// the wake scan compares through the shared adder
// throughput: one item at a time, busy high until the result beat is out
// reset: asynchronous, counts, pointers and result registers cleared; the receiver cannot stall
// depends on rrs_pkg and rrs_alu
module round_robin_scheduler_with_sleep #(
    parameter int MAX_THREADS = rrs_pkg::DEF_MAX_THREADS,
    parameter int TICK_BITS   = rrs_pkg::DEF_TICK_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [rrs_pkg::CMD_W-1:0]     cmd,
    input  logic [rrs_pkg::ID_W-1:0]      thread_id,
    input  logic [rrs_pkg::DELAY_W-1:0]   sleep_ticks,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rrs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rrs_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                          done,
    output logic [rrs_pkg::ID_W-1:0]      active_thread,
    output logic [rrs_pkg::ID_W-1:0]      previous_thread,
    output logic                          switched,
    output logic [rrs_pkg::WOKEN_W-1:0]   woken,
    output logic [rrs_pkg::STATUS_W-1:0]  status
);
    import rrs_pkg::*;

    localparam int IW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam int CW = $clog2(MAX_THREADS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_THREADS);

    // one-hot sequencer
    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_PREV   = 9'b000000010,
        S_TICK   = 9'b000000100,
        S_WCHK   = 9'b000001000,
        S_WSHIFT = 9'b000010000,
        S_SLP    = 9'b000100000,
        S_RSHIFT = 9'b001000000,
        S_ROT    = 9'b010000000,
        S_FIN    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic               run_reg;
    logic [QUANT_W-1:0] quant_reg;

    // latched input beat
    logic [CMD_W-1:0]   cmd_reg;
    logic [ID_W-1:0]    tid_reg;
    logic [DELAY_W-1:0] delay_reg;

    // scheduler state
    logic [TICK_BITS-1:0] tick_reg;
    logic [QUANT_W-1:0]   phase_reg;
    logic [CW-1:0]        rcount_reg;
    logic [CW-1:0]        scount_reg;
    logic [IW-1:0]        slot_reg;
    logic [CW-1:0]        idx_reg;     // scan index / ring shift index
    logic [CW-1:0]        jdx_reg;     // sleep-list shift index

    // storage, no reset: entries beyond the counts are never read
    logic [ID_W-1:0]      ring_mem [MAX_THREADS];
    logic [ID_W-1:0]      sid_mem  [MAX_THREADS];
    logic [TICK_BITS-1:0] swake_mem[MAX_THREADS];

    // result registers
    logic [ID_W-1:0]     prev_reg;
    logic                sw_reg;
    logic [WOKEN_W-1:0]  woken_reg;
    logic [STATUS_W-1:0] st_reg;
    logic [ID_W-1:0]     act_reg;
    logic                done_reg;

    // shared unit
    alu_op_t              alu_op;
    logic [TICK_BITS-1:0] alu_a, alu_b, alu_sum;
    logic                 alu_gt;

    rrs_alu #(
        .TICK_BITS (TICK_BITS)
    ) u_alu (
        .op     (alu_op),
        .a      (alu_a),
        .b      (alu_b),
        .sum    (alu_sum),
        .a_gt_b (alu_gt)
    );

    // single read port per store
    logic [CW-1:0]        ring_raddr;
    logic [CW-1:0]        sl_raddr;
    logic [ID_W-1:0]      ring_rdata;
    logic [ID_W-1:0]      sid_rdata;
    logic [TICK_BITS-1:0] swake_rdata;

    // single write port per store
    logic                 ring_we;
    logic [CW-1:0]        ring_waddr;
    logic [ID_W-1:0]      ring_wdata;
    logic                 sl_we;
    logic [CW-1:0]        sl_waddr;
    logic [ID_W-1:0]      sid_wdata;
    logic [TICK_BITS-1:0] swake_wdata;

    logic [QUANT_W-1:0] phase_inc;
    logic [QUANT_W-1:0] quant_eff;
    logic [CW-1:0]      idx_inc;
    logic [CW-1:0]      jdx_inc;
    logic [CW-1:0]      slot_inc;
    logic               ring_full;
    logic               ring_empty;

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    assign phase_inc  = phase_reg + 1'b1;
    assign quant_eff  = (quant_reg == '0) ? QUANT_W'(1) : quant_reg;
    assign idx_inc    = idx_reg + 1'b1;
    assign jdx_inc    = jdx_reg + 1'b1;
    assign slot_inc   = CW'(slot_reg) + 1'b1;
    assign ring_full  = (rcount_reg >= MAX_CNT);
    assign ring_empty = (rcount_reg == '0);

    assign ring_raddr  = (state_reg == S_RSHIFT) ? idx_inc : CW'(slot_reg);
    assign sl_raddr    = (state_reg == S_WSHIFT) ? jdx_inc : idx_reg;
    assign ring_rdata  = ring_mem[ring_raddr[IW-1:0]];
    assign sid_rdata   = sid_mem[sl_raddr[IW-1:0]];
    assign swake_rdata = swake_mem[sl_raddr[IW-1:0]];

    // operand selection for the shared adder
    always_comb
    begin
        alu_op = ALU_ADD;
        alu_a  = tick_reg;
        alu_b  = TICK_BITS'(1);
        case (state_reg)
            S_SLP:
            begin
                alu_b = TICK_BITS'(delay_reg);
            end
            S_WCHK:
            begin
                alu_op = ALU_GT;
                alu_b  = swake_rdata;
            end
            default:
            begin
                alu_op = ALU_ADD;
            end
        endcase
    end

    // write port steering
    always_comb
    begin
        ring_we     = 1'b0;
        ring_waddr  = rcount_reg;
        ring_wdata  = tid_reg;
        sl_we       = 1'b0;
        sl_waddr    = scount_reg;
        sid_wdata   = prev_reg;
        swake_wdata = alu_sum;
        case (state_reg)
            S_PREV:
            begin
                // admit appends at the tail
                ring_we = (cmd_reg == CMD_ADMIT) && !ring_full;
            end
            S_WCHK:
            begin
                ring_we    = (idx_reg < scount_reg) && alu_gt && !ring_full;
                ring_wdata = sid_rdata;
            end
            S_RSHIFT:
            begin
                ring_we    = (idx_inc < rcount_reg);
                ring_waddr = idx_reg;
                ring_wdata = ring_rdata;
            end
            S_SLP:
            begin
                sl_we = 1'b1;
            end
            S_WSHIFT:
            begin
                sl_we       = (jdx_inc < scount_reg);
                sl_waddr    = jdx_reg;
                sid_wdata   = sid_rdata;
                swake_wdata = swake_rdata;
            end
            default:
            begin
                ring_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[ring_waddr[IW-1:0]] <= ring_wdata;
        end
        if (sl_we)
        begin
            sid_mem[sl_waddr[IW-1:0]]   <= sid_wdata;
            swake_mem[sl_waddr[IW-1:0]] <= swake_wdata;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_PREV;
                end
            end
            S_PREV:
            begin
                case (cmd_reg)
                    CMD_TICK:  state_next = run_reg ? S_TICK : S_FIN;
                    CMD_SLEEP: state_next = (ring_empty || scount_reg >= MAX_CNT) ? S_FIN : S_SLP;
                    CMD_EXIT:  state_next = ring_empty ? S_FIN : S_RSHIFT;
                    default:   state_next = S_FIN;
                endcase
            end
            S_TICK:
            begin
                state_next = (phase_inc >= quant_eff) ? S_WCHK : S_FIN;
            end
            S_WCHK:
            begin
                if (idx_reg >= scount_reg)
                begin
                    state_next = S_ROT;
                end
                else if (alu_gt && !ring_full)
                begin
                    state_next = S_WSHIFT;
                end
            end
            S_WSHIFT:
            begin
                if (!(jdx_inc < scount_reg))
                begin
                    state_next = S_WCHK;
                end
            end
            S_SLP:
            begin
                state_next = S_RSHIFT;
            end
            S_RSHIFT:
            begin
                if (!(idx_inc < rcount_reg))
                begin
                    state_next = S_FIN;
                end
            end
            S_ROT:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // configuration beats
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            quant_reg <= QUANT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_RUN_ENABLE)
            begin
                run_reg <= cfg_data[0];
            end
            else if (cfg_index == CFG_QUANTUM_TICKS)
            begin
                quant_reg <= cfg_data;
            end
        end
    end

    // input beat latch, payload only
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg   <= cmd;
            tid_reg   <= thread_id;
            delay_reg <= sleep_ticks;
        end
    end

    // sequencer datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            tick_reg   <= '0;
            phase_reg  <= '0;
            rcount_reg <= '0;
            scount_reg <= '0;
            slot_reg   <= '0;
            idx_reg    <= '0;
            jdx_reg    <= '0;
            prev_reg   <= '0;
            sw_reg     <= 1'b0;
            woken_reg  <= '0;
            st_reg     <= ST_OK;
            act_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    sw_reg    <= 1'b0;
                    woken_reg <= '0;
                    st_reg    <= ST_OK;
                end
                S_PREV:
                begin
                    prev_reg <= ring_empty ? '0 : ring_rdata;
                    case (cmd_reg)
                        CMD_SLEEP:
                        begin
                            if (ring_empty)
                            begin
                                st_reg <= ST_EMPTY;
                            end
                            else if (scount_reg >= MAX_CNT)
                            begin
                                st_reg <= ST_FULL;
                            end
                        end
                        CMD_EXIT:
                        begin
                            if (ring_empty)
                            begin
                                st_reg <= ST_EMPTY;
                            end
                            else
                            begin
                                idx_reg <= CW'(slot_reg);
                                sw_reg  <= (rcount_reg > CW'(1));
                            end
                        end
                        CMD_ADMIT:
                        begin
                            if (ring_full)
                            begin
                                st_reg <= ST_FULL;
                            end
                            else
                            begin
                                rcount_reg <= rcount_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                            idx_reg <= '0;
                        end
                    endcase
                end
                S_TICK:
                begin
                    tick_reg <= alu_sum;
                    idx_reg  <= '0;
                    // decision once the phase reaches the quantum
                    phase_reg <= (phase_inc >= quant_eff) ? '0 : phase_inc;
                end
                S_WCHK:
                begin
                    if (idx_reg < scount_reg)
                    begin
                        if (alu_gt && !ring_full)
                        begin
                            rcount_reg <= rcount_reg + 1'b1;
                            woken_reg  <= woken_reg + 1'b1;
                            jdx_reg    <= idx_reg;
                        end
                        else
                        begin
                            if (alu_gt)
                            begin
                                st_reg <= ST_FULL;
                            end
                            idx_reg <= idx_inc;
                        end
                    end
                end
                S_WSHIFT:
                begin
                    if (jdx_inc < scount_reg)
                    begin
                        jdx_reg <= jdx_inc;
                    end
                    else
                    begin
                        scount_reg <= scount_reg - 1'b1;
                    end
                end
                S_SLP:
                begin
                    scount_reg <= scount_reg + 1'b1;
                    idx_reg    <= CW'(slot_reg);
                    sw_reg     <= (rcount_reg > CW'(1));
                end
                S_RSHIFT:
                begin
                    if (idx_inc < rcount_reg)
                    begin
                        idx_reg <= idx_inc;
                    end
                    else
                    begin
                        // successor slides into the removed slot, or wrap to head
                        rcount_reg <= rcount_reg - 1'b1;
                        if (!(slot_inc < rcount_reg))
                        begin
                            slot_reg <= '0;
                        end
                    end
                end
                S_ROT:
                begin
                    if (ring_empty)
                    begin
                        st_reg <= ST_EMPTY;
                    end
                    else
                    begin
                        sw_reg   <= (rcount_reg > CW'(1));
                        slot_reg <= (slot_inc >= rcount_reg) ? '0 : slot_inc[IW-1:0];
                    end
                end
                S_FIN:
                begin
                    act_reg  <= ring_empty ? '0 : ring_rdata;
                    done_reg <= 1'b1;
                end
                default:
                begin
                    done_reg <= 1'b0;
                end
            endcase
        end
    end

    assign done            = done_reg;
    assign active_thread   = act_reg;
    assign previous_thread = prev_reg;
    assign switched        = sw_reg;
    assign woken           = woken_reg;
    assign status          = st_reg;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (state_reg == S_IDLE))
        else $error("result beat while sequencer busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat held for more than one cycle");
    a_ring_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rcount_reg <= MAX_CNT)
        else $error("ready ring count overflow");
    a_sleep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scount_reg <= MAX_CNT)
        else $error("sleep list count overflow");
    a_slot_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && rcount_reg != '0) |-> (CW'(slot_reg) < rcount_reg))
        else $error("active slot outside ready ring");
`endif

endmodule
